[src/dmgb_pkg.sv]
// ----------------------------------------------------------------------------
// dmgb_pkg
// Shared types, constants and helper functions for the dot-matrix glyph
// blitter: command and merge codes, sequencer states, item and result records.
// ----------------------------------------------------------------------------
package dmgb_pkg;

    // Default geometry, handed to the top level parameters
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 64;

    // Fixed store layout (row alignment must be a power of two, at least 8)
    localparam int ROW_ALIGN_BITS    = 32;
    localparam int ALIGN_SHIFT       = $clog2(ROW_ALIGN_BITS);
    localparam int ALIGN_BYTES_SHIFT = ALIGN_SHIFT - 3;
    localparam int GLYPH_COLUMNS     = 16;
    localparam int GLYPH_ROWS        = 16;
    localparam int GLYPH_BYTES       = GLYPH_COLUMNS / 8;
    localparam int GB_W              = (GLYPH_BYTES > 1) ? $clog2(GLYPH_BYTES) : 1;

    // Field and port widths
    localparam int CMD_W     = 2;
    localparam int X_W       = 10;
    localparam int Y_W       = 8;
    localparam int LINE_W    = 4;
    localparam int BITS_W    = 16;
    localparam int MODE_W    = 2;
    localparam int PW_W      = 9;
    localparam int PH_W      = 7;
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int COL_W     = 11;   // column sums: dot_x plus glyph byte offset
    localparam int ROW_W     = 9;    // row sums: dot_y plus glyph line
    localparam int BYTE_W    = 8;    // byte column within a row

    // Register index, as decoded from paddr[2]
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_STAMP  = 2'd0,
        CMD_TEST   = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_BOUNDS = 2'd3
    } cmd_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_REPLACE = 2'd0,
        MODE_OR      = 2'd1,
        MODE_XOR     = 2'd2,
        MODE_ANDNOT  = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_SETUP,
        ST_STAMP_RD,
        ST_STAMP_WR,
        ST_TEST_RD,
        ST_TEST_WAIT,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } st_t;

    typedef struct packed {
        mode_t              mode;
        logic [BITS_W-1:0]  bits;
        logic [LINE_W-1:0]  line;
        logic [Y_W-1:0]     y;
        logic [X_W-1:0]     x;
        cmd_t               cmd;
    } item_t;

    // Packed so that dot_lit sits in the lowest bit
    typedef struct packed {
        logic [5:0] bottom;
        logic [7:0] right;
        logic [5:0] top;
        logic [7:0] left;
        logic       bounds_empty;
        logic       dot_lit;
    } res_t;

    function automatic logic [7:0] merge_byte(input logic [7:0] d, input logic [7:0] s,
                                              input mode_t mode);
        logic [7:0] r;
        case (mode)
            MODE_REPLACE: r = s;
            MODE_OR:      r = d | s;
            MODE_XOR:     r = d ^ s;
            MODE_ANDNOT:  r = d & ~s;
            default:      r = s;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] low_bit(input logic [7:0] b);
        logic [2:0] r;
        r = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (b[i]) r = 3'(i);
        end
        return r;
    endfunction

    function automatic logic [2:0] high_bit(input logic [7:0] b);
        logic [2:0] r;
        r = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) r = 3'(i);
        end
        return r;
    endfunction

endpackage

[src/dmgb_ram.sv]
// ----------------------------------------------------------------------------
// dmgb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dmgb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/dmgb_engine.sv]
// ----------------------------------------------------------------------------
// dmgb_engine
// Command sequencer around the dot store: one shared address/merge unit does
// the read-modify-write of stamps, dot tests, clearing sweeps and bounds scans.
// ----------------------------------------------------------------------------
module dmgb_engine
    import dmgb_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [PW_W-1:0] panel_width,
    input  logic [PH_W-1:0] panel_height,
    input  logic            item_valid,
    input  item_t           item,
    output logic            item_ready,
    output logic            res_valid,
    output res_t            res,
    input  logic            res_free
);

    localparam int WW          = $clog2(MAX_WIDTH + 1);
    localparam int CW          = (WW > PW_W) ? WW : PW_W;
    localparam int HW          = $clog2(MAX_HEIGHT + 1);
    localparam int CH          = (HW > PH_W) ? HW : PH_W;
    localparam int MAX_STRIDE  = ((MAX_WIDTH + ROW_ALIGN_BITS - 1) / ROW_ALIGN_BITS)
                                 * (ROW_ALIGN_BITS / 8);
    localparam int SW          = $clog2(MAX_STRIDE + 1);
    localparam int STORE_BYTES = MAX_STRIDE * MAX_HEIGHT;
    localparam int AW          = $clog2(STORE_BYTES);
    localparam int EW          = (CW > SW + 3) ? CW : SW + 3;
    localparam int PW          = ROW_W + SW;

    st_t              state_reg, state_next;
    item_t            item_reg;
    logic             reply_reg;
    logic [AW-1:0]    sweep_reg;
    logic [AW-1:0]    row_base_reg;
    logic [GB_W-1:0]  gb_reg;
    logic             en_reg;
    logic [AW-1:0]    waddr_reg;
    logic             lit_reg;
    logic [CH-1:0]    row_reg;
    logic [SW-1:0]    k_reg;
    logic             p_valid_reg;
    logic [CH-1:0]    p_row_reg;
    logic [SW-1:0]    p_k_reg;
    logic             found_reg;
    logic [EW-1:0]    l_reg, r_reg;
    logic [CH-1:0]    t_reg, b_reg;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [7:0]       ram_wdata, ram_rdata;

    // Geometry
    logic [CW-1:0]    eff_w;
    logic [CH-1:0]    eff_h;
    logic [CW:0]      wsum, stride_full, bpr_full;
    logic [SW-1:0]    stride, bpr;

    // Shared address and merge unit
    logic [ROW_W-1:0]  row_sum, mul_row;
    logic [PW-1:0]     prod;
    logic              stamp_ok, test_ok, bounds_ok;
    logic [BYTE_W-1:0] byte_idx;
    logic [COL_W-1:0]  dot_col;
    logic              stamp_en;
    logic [7:0]        src_byte;
    logic              gb_last, sweep_last, scan_row_end, scan_last;

    // Scan evaluation
    logic [EW-1:0]    colbase, rem, col_lo, col_hi;
    logic [7:0]       mask, hit;

    dmgb_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        eff_w       = (CW'(panel_width) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(panel_width);
        eff_h       = (CH'(panel_height) > CH'(MAX_HEIGHT)) ? CH'(MAX_HEIGHT)
                                                            : CH'(panel_height);
        wsum        = {1'b0, eff_w} + (CW+1)'(ROW_ALIGN_BITS - 1);
        stride_full = (wsum >> ALIGN_SHIFT) << ALIGN_BYTES_SHIFT;
        stride      = SW'(stride_full);
        bpr_full    = ({1'b0, eff_w} + (CW+1)'(7)) >> 3;
        bpr         = SW'(bpr_full);
    end

    always_comb begin
        row_sum   = ROW_W'(item_reg.y) + ROW_W'(item_reg.line);
        mul_row   = (item_reg.cmd == CMD_TEST) ? ROW_W'(item_reg.y) : row_sum;
        prod      = PW'(mul_row) * PW'(stride);
        stamp_ok  = (item_reg.x[2:0] == 3'd0)
                    && (6'(item_reg.line) < 6'(GLYPH_ROWS))
                    && (row_sum < ROW_W'(eff_h));
        test_ok   = (COL_W'(item_reg.x) < COL_W'(eff_w))
                    && (ROW_W'(item_reg.y) < ROW_W'(eff_h));
        bounds_ok = (eff_w != '0) && (eff_h != '0);
        byte_idx  = BYTE_W'(item_reg.x[X_W-1:3]) + BYTE_W'(gb_reg);
        dot_col   = COL_W'(item_reg.x) + COL_W'({gb_reg, 3'b000});
        stamp_en  = (dot_col < COL_W'(eff_w)) && (byte_idx < BYTE_W'(stride));
        src_byte  = 8'(item_reg.bits >> {gb_reg, 3'b000});
        gb_last   = (gb_reg == GB_W'(GLYPH_BYTES - 1));
        sweep_last   = (sweep_reg == AW'(STORE_BYTES - 1));
        scan_row_end = (k_reg == SW'(bpr - 1'b1));
        scan_last    = scan_row_end && (row_reg == CH'(eff_h - 1'b1));
    end

    // Mask off dots past the panel width in the byte being evaluated
    always_comb begin
        colbase = EW'({p_k_reg, 3'b000});
        rem     = EW'(eff_w) - colbase;
        mask    = (rem >= EW'(8)) ? 8'hFF : ~(8'hFF << rem[2:0]);
        hit     = ram_rdata & mask;
        col_lo  = colbase + EW'(low_bit(hit));
        col_hi  = colbase + EW'(high_bit(hit));
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_SWEEP: begin
                if (sweep_last) state_next = reply_reg ? ST_DONE : ST_IDLE;
            end
            ST_IDLE: begin
                if (item_valid) state_next = ST_SETUP;
            end
            ST_SETUP: begin
                case (item_reg.cmd)
                    CMD_STAMP:  state_next = stamp_ok ? ST_STAMP_RD : ST_DONE;
                    CMD_TEST:   state_next = test_ok ? ST_TEST_RD : ST_DONE;
                    CMD_CLEAR:  state_next = ST_SWEEP;
                    CMD_BOUNDS: state_next = bounds_ok ? ST_SCAN : ST_DONE;
                    default:    state_next = ST_DONE;
                endcase
            end
            ST_STAMP_RD:  state_next = ST_STAMP_WR;
            ST_STAMP_WR:  state_next = gb_last ? ST_DONE : ST_STAMP_RD;
            ST_TEST_RD:   state_next = ST_TEST_WAIT;
            ST_TEST_WAIT: state_next = ST_DONE;
            ST_SCAN: begin
                if (scan_last) state_next = ST_DRAIN;
            end
            ST_DRAIN:     state_next = ST_DONE;
            ST_DONE: begin
                if (res_free) state_next = ST_IDLE;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ram_we     = 1'b0;
        ram_waddr  = waddr_reg;
        ram_wdata  = merge_byte(ram_rdata, src_byte, item_reg.mode);
        ram_raddr  = row_base_reg;
        item_ready = 1'b0;
        res_valid  = 1'b0;
        case (state_reg)
            ST_SWEEP: begin
                ram_we    = 1'b1;
                ram_waddr = sweep_reg;
                ram_wdata = 8'h00;
            end
            ST_IDLE:     item_ready = 1'b1;
            ST_STAMP_RD: ram_raddr  = row_base_reg + AW'(byte_idx);
            ST_STAMP_WR: ram_we     = en_reg;
            ST_TEST_RD:  ram_raddr  = row_base_reg + AW'(item_reg.x[X_W-1:3]);
            ST_SCAN:     ram_raddr  = row_base_reg + AW'(k_reg);
            ST_DONE:     res_valid  = 1'b1;
            default: begin
            end
        endcase
    end

    always_comb begin
        res              = '0;
        res.dot_lit      = (item_reg.cmd == CMD_TEST) && lit_reg;
        res.bounds_empty = (item_reg.cmd == CMD_BOUNDS) && !found_reg;
        if (item_reg.cmd == CMD_BOUNDS) begin
            res.left   = 8'(l_reg);
            res.top    = 6'(t_reg);
            res.right  = 8'(r_reg);
            res.bottom = 6'(b_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_SWEEP;
            sweep_reg   <= '0;
            reply_reg   <= 1'b0;
            p_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            p_valid_reg <= (state_reg == ST_SCAN);
            if (state_reg == ST_SWEEP) begin
                sweep_reg <= sweep_last ? '0 : sweep_reg + 1'b1;
            end
            if (state_reg == ST_SETUP) begin
                reply_reg <= (item_reg.cmd == CMD_CLEAR);
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (item_valid) item_reg <= item;
            end
            ST_SETUP: begin
                row_base_reg <= (item_reg.cmd == CMD_BOUNDS) ? '0 : prod[AW-1:0];
                gb_reg       <= '0;
                lit_reg      <= 1'b0;
                found_reg    <= 1'b0;
                l_reg        <= '0;
                r_reg        <= '0;
                t_reg        <= '0;
                b_reg        <= '0;
                row_reg      <= '0;
                k_reg        <= '0;
            end
            ST_STAMP_RD: begin
                en_reg    <= stamp_en;
                waddr_reg <= row_base_reg + AW'(byte_idx);
            end
            ST_STAMP_WR: gb_reg <= gb_reg + 1'b1;
            ST_TEST_WAIT: lit_reg <= ram_rdata[item_reg.x[2:0]];
            ST_SCAN: begin
                p_row_reg <= row_reg;
                p_k_reg   <= k_reg;
                if (scan_row_end) begin
                    k_reg        <= '0;
                    row_reg      <= row_reg + 1'b1;
                    row_base_reg <= row_base_reg + AW'(stride);
                end else begin
                    k_reg <= k_reg + 1'b1;
                end
            end
            default: begin
            end
        endcase

        // Fold the byte read in the previous scan cycle into the box
        if (p_valid_reg && (hit != 8'h00)) begin
            found_reg <= 1'b1;
            b_reg     <= p_row_reg;
            if (!found_reg) begin
                l_reg <= col_lo;
                r_reg <= col_hi;
                t_reg <= p_row_reg;
            end else begin
                if (col_lo < l_reg) l_reg <= col_lo;
                if (col_hi > r_reg) r_reg <= col_hi;
            end
        end
    end

endmodule

[src/dot_matrix_glyph_blitter_top.sv]
// ----------------------------------------------------------------------------
// Bounds scans read one store byte per cycle. One item is in work at a time;
// the next is taken once the result is in the output register. All store reads
// go through one RAM read port and all writes through one write port.
// Reset: synchronous, active low; registers return to 256 x 64 and the store is
// swept to zero one byte a cycle (all STORE_BYTES bytes, 2048 by default) before
// the first item is taken. Configuration writes are accepted throughout.
// ----------------------------------------------------------------------------
// dot_matrix_glyph_blitter_top
// Monochrome panel bitmap with glyph line stamping, dot test, clear and
// lit-dot bounding box, behind a stream input, stream output and APB port.
// ----------------------------------------------------------------------------
module dot_matrix_glyph_blitter_top
    import dmgb_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // APB configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready,
    // Command stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // dot_x[9:0], dot_y[17:10], glyph_line[21:18], line_bits[37:22], merge_mode[39:38]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // command[1:0]
    input  logic [S_TUSER_W-1:0] s_tuser,
    // Result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // dot_lit[0], bounds_empty[1], bound_left[9:2], bound_top[15:10],
    // bound_right[23:16], bound_bottom[29:24], zero[31:30]
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic [PW_W-1:0]      panel_width_reg;
    logic [PH_W-1:0]      panel_height_reg;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 cfg_write;
    item_t                item;
    res_t                 res;
    logic                 res_valid;
    logic                 res_free;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_HEIGHT) ? PDATA_W'(panel_height_reg)
                                                : PDATA_W'(panel_width_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            panel_width_reg  <= PW_W'(256);
            panel_height_reg <= PH_W'(64);
        end else if (cfg_write) begin
            if (paddr[2] == REG_WIDTH) begin
                panel_width_reg <= pwdata[PW_W-1:0];
            end else begin
                panel_height_reg <= pwdata[PH_W-1:0];
            end
        end
    end

    always_comb begin
        item.cmd  = cmd_t'(s_tuser[CMD_W-1:0]);
        item.x    = s_tdata[9:0];
        item.y    = s_tdata[17:10];
        item.line = s_tdata[21:18];
        item.bits = s_tdata[37:22];
        item.mode = mode_t'(s_tdata[39:38]);
    end

    assign res_free = !m_tvalid_reg || m_tready;

    dmgb_engine #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .panel_width  (panel_width_reg),
        .panel_height (panel_height_reg),
        .item_valid   (s_tvalid),
        .item         (item),
        .item_ready   (s_tready),
        .res_valid    (res_valid),
        .res          (res),
        .res_free     (res_free)
    );

    // Output register: hold the result until the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid && res_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_free) begin
            m_tdata_reg <= M_TDATA_W'(res);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[src/dmgb_checker.sv]
// ----------------------------------------------------------------------------
// dmgb_checker
// Port-level checks on the glyph blitter's streams, bound to the top level.
// ----------------------------------------------------------------------------
module dmgb_checker
    import dmgb_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // The store is swept after reset, so no command is taken straight away
    a_busy_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("command taken right after reset");

    // One command at a time: a transfer in closes the input for the next cycle
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input still open after a command transfer");

    // An empty box reports all-zero coordinates and no dot answer
    a_empty_box_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1]) |-> (m_tdata[29:2] == '0) && !m_tdata[0])
        else $error("empty bounds with non-zero fields");

    // A stalled result stays offered
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped before transfer");

endmodule

bind dot_matrix_glyph_blitter_top dmgb_checker u_dmgb_checker (.*);

[bench/dot_matrix_glyph_blitter_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dot_matrix_glyph_blitter_top_tb
// Drives glyph stamps, dot probes, clears and bounding box scans into the
// blitter under several panel sizes. A bit-level copy of the panel store
// predicts every answer, and each result transfer is checked field by field.
// ----------------------------------------------------------------------------
module dot_matrix_glyph_blitter_top_tb;
    import dmgb_pkg::*;

    localparam int STORE_BYTES = ((MAX_WIDTH_DEF + ROW_ALIGN_BITS - 1) / ROW_ALIGN_BITS)
                                 * (ROW_ALIGN_BITS / 8) * MAX_HEIGHT_DEF;
    localparam int QUIET_LIMIT = 20000;
    localparam int TAIL_CYCLES = 2200;
    localparam int STALL_HOLD  = 400;
    localparam logic [PADDR_W-1:0] ADDR_PANEL_WIDTH  = {REG_WIDTH, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_PANEL_HEIGHT = {REG_HEIGHT, 2'b00};

    typedef struct {
        cmd_t              op;
        logic [X_W-1:0]    x;
        logic [Y_W-1:0]    y;
        logic [LINE_W-1:0] line;
        logic [BITS_W-1:0] bits;
        mode_t             mode;
    } blit_cmd_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Predicted panel state
    logic [7:0]      panel_bits [STORE_BYTES];
    logic [PW_W-1:0] panel_width_q = 9'd256;
    logic [PH_W-1:0] panel_height_q = 7'd64;
    res_t            expected_answers [$];

    int  mismatches = 0;
    int  n_commands = 0;
    int  n_answers = 0;
    int  n_lit = 0;
    int  n_boxes = 0;
    int  n_settings = 0;
    int  quiet_cycles = 0;
    int  hold_request = 0;
    int  hold_left = 0;
    bit  steady_flow = 1'b0;

    always #10 aclk = ~aclk;

    dot_matrix_glyph_blitter_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // ------------------------------------------------------------------------
    // Panel predictor
    // ------------------------------------------------------------------------
    function automatic int eff_width();
        return (panel_width_q > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(panel_width_q);
    endfunction

    function automatic int eff_height();
        return (panel_height_q > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(panel_height_q);
    endfunction

    function automatic int row_stride(int w);
        return ((w + ROW_ALIGN_BITS - 1) / ROW_ALIGN_BITS) * (ROW_ALIGN_BITS / 8);
    endfunction

    function automatic bit dot_is_lit(int col, int row);
        int idx;
        if (col >= eff_width() || row >= eff_height()) return 1'b0;
        idx = row * row_stride(eff_width()) + col / 8;
        if (idx >= STORE_BYTES) return 1'b0;
        return panel_bits[idx][col % 8];
    endfunction

    function automatic void stamp_line(blit_cmd_t c);
        int         w;
        int         stride;
        int         row;
        int         dot;
        int         byte_col;
        int         idx;
        logic [7:0] src;
        logic [7:0] d;
        w = eff_width();
        stride = row_stride(w);
        row = int'(c.y) + int'(c.line);
        if (c.x % 8 != 0 || c.line >= GLYPH_ROWS || row >= eff_height()) return;
        for (int i = 0; i < GLYPH_BYTES; i++) begin
            dot = int'(c.x) + 8 * i;
            byte_col = int'(c.x) / 8 + i;
            idx = row * stride + byte_col;
            if (dot >= w || byte_col >= stride || idx >= STORE_BYTES) continue;
            src = c.bits[8*i +: 8];
            d = panel_bits[idx];
            case (c.mode)
                MODE_REPLACE: d = src;
                MODE_OR:      d = d | src;
                MODE_XOR:     d = d ^ src;
                default:      d = d & ~src;
            endcase
            panel_bits[idx] = d;
        end
    endfunction

    function automatic res_t predict_result(blit_cmd_t c);
        res_t r;
        int   w;
        int   h;
        int   l;
        int   t;
        int   rt;
        int   b;
        bit   found;
        r = '0;
        w = eff_width();
        h = eff_height();
        l = 0;
        t = 0;
        rt = 0;
        b = 0;
        found = 1'b0;
        case (c.op)
            CMD_STAMP: stamp_line(c);
            CMD_TEST:  r.dot_lit = dot_is_lit(int'(c.x), int'(c.y));
            CMD_CLEAR: foreach (panel_bits[i]) panel_bits[i] = '0;
            default: begin
                for (int row = 0; row < h; row++) begin
                    for (int col = 0; col < w; col++) begin
                        if (!dot_is_lit(col, row)) continue;
                        if (!found) begin
                            l = col;
                            rt = col;
                            t = row;
                            b = row;
                            found = 1'b1;
                        end else begin
                            if (col < l) l = col;
                            if (col > rt) rt = col;
                            b = row;
                        end
                    end
                end
                r.bounds_empty = !found;
                r.left = l[7:0];
                r.top = t[5:0];
                r.right = rt[7:0];
                r.bottom = b[5:0];
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking and receiver
    // ------------------------------------------------------------------------
    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_answer(logic [M_TDATA_W-1:0] data);
        res_t want;
        res_t got;
        got = res_t'(data[$bits(res_t)-1:0]);
        if (expected_answers.size() == 0) begin
            $display("%0t: result 0x%h with no command outstanding", $time, data);
            mismatches++;
            return;
        end
        want = expected_answers.pop_front();
        n_answers++;
        if (got.dot_lit) n_lit++;
        if (!got.bounds_empty && want.left != want.right) n_boxes++;
        check_field("dot_lit", want.dot_lit, got.dot_lit);
        check_field("bounds_empty", want.bounds_empty, got.bounds_empty);
        check_field("bound_left", want.left, got.left);
        check_field("bound_top", want.top, got.top);
        check_field("bound_right", want.right, got.right);
        check_field("bound_bottom", want.bottom, got.bottom);
        check_field("tdata padding", 0, data[M_TDATA_W-1:$bits(res_t)]);
    endfunction

    always @(posedge aclk) begin
        if (m_tvalid && m_tready) check_answer(m_tdata);
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= steady_flow || ($urandom_range(0, 99) >= 30);
        end
    end

    // Watchdog: count cycles in which no transfer happens on either stream
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout after %0d quiet cycles at %0t", quiet_cycles, $time);
            $display("dot_matrix_glyph_blitter_top test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic send_cmd(input blit_cmd_t c);
        if (!steady_flow && $urandom_range(0, 99) < 30) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c.op;
        s_tdata  <= {c.mode, c.bits, c.line, c.y, c.x};
        do @(posedge aclk); while (!s_tready);
        expected_answers.push_back(predict_result(c));
        n_commands++;
    endtask

    task automatic do_stamp(input int x, input int y, input int line, input int bits,
                            input mode_t mode);
        blit_cmd_t c;
        c = '{CMD_STAMP, X_W'(x), Y_W'(y), LINE_W'(line), BITS_W'(bits), mode};
        send_cmd(c);
    endtask

    task automatic do_probe(input int x, input int y);
        blit_cmd_t c;
        c = '{CMD_TEST, X_W'(x), Y_W'(y), LINE_W'($urandom()), BITS_W'($urandom()),
              mode_t'($urandom_range(0, 3))};
        send_cmd(c);
    endtask

    // Clear and bounds carry random data fields, which the block must ignore
    task automatic do_scan(input cmd_t op);
        blit_cmd_t c;
        c = '{op, X_W'($urandom()), Y_W'($urandom()), LINE_W'($urandom()),
              BITS_W'($urandom()), mode_t'($urandom_range(0, 3))};
        send_cmd(c);
    endtask

    // Drop valid and hold until every outstanding result has been transferred
    task automatic settle_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_answers.size() != 0);
    endtask

    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_PANEL_WIDTH) panel_width_q = value[PW_W-1:0];
        else panel_height_q = value[PH_W-1:0];
    endtask

    // Upper data bits are random; only the register's own width must stick
    task automatic set_panel(input int w, input int h);
        logic [PDATA_W-1:0] wval;
        logic [PDATA_W-1:0] hval;
        wval = $urandom();
        hval = $urandom();
        wval[PW_W-1:0] = PW_W'(w);
        hval[PH_W-1:0] = PH_W'(h);
        settle_results();
        write_reg(ADDR_PANEL_WIDTH, wval);
        write_reg(ADDR_PANEL_HEIGHT, hval);
        n_settings++;
    endtask

    function automatic int pick_stamp_x();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return 8 * $urandom_range(0, eff_width() / 8 + 1);
        if (r < 95) return 8 * $urandom_range(0, 127);
        return $urandom_range(0, 1023);
    endfunction

    function automatic int pick_row();
        if ($urandom_range(0, 99) < 85) return $urandom_range(0, eff_height());
        return $urandom_range(0, 255);
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed_commands();
        do_stamp(0, 0, 0, 16'hFFFF, MODE_REPLACE);
        do_probe(0, 0);
        do_probe(15, 0);
        do_probe(16, 0);
        // second glyph byte falls past the right edge
        do_stamp(248, 60, 3, 16'h5AC3, MODE_OR);
        do_probe(255, 63);
        do_stamp(0, 0, 0, 16'h00F0, MODE_XOR);
        do_stamp(8, 0, 0, 16'h0081, MODE_ANDNOT);
        do_stamp(3, 5, 0, 16'hFFFF, MODE_REPLACE);
        do_stamp(0, 60, 4, 16'hFFFF, MODE_REPLACE);
        do_stamp(0, 255, 15, 16'hFFFF, MODE_OR);
        do_stamp(1016, 0, 0, 16'hFFFF, MODE_OR);
        do_stamp(1023, 0, 0, 16'hFFFF, MODE_OR);
        do_probe(1023, 255);
        do_probe(256, 0);
        do_probe(0, 64);
        do_scan(CMD_BOUNDS);
        do_scan(CMD_CLEAR);
        do_scan(CMD_BOUNDS);
        do_stamp(120, 30, 15, 16'h0000, MODE_REPLACE);
        do_stamp(120, 30, 15, 16'h8001, MODE_OR);
        do_scan(CMD_BOUNDS);
    endtask

    task automatic test_register_extremes();
        // zero-sized panel: nothing is stored or seen
        set_panel(0, 0);
        do_stamp(0, 0, 0, 16'hFFFF, MODE_OR);
        do_probe(0, 0);
        do_scan(CMD_BOUNDS);
        // oversized registers saturate to the store geometry
        set_panel(511, 127);
        do_scan(CMD_BOUNDS);
        do_probe(127, 45);
        // narrow stride reinterprets the kept store
        set_panel(32, 4);
        do_scan(CMD_BOUNDS);
        do_stamp(24, 3, 0, 16'hFFFF, MODE_OR);
        do_scan(CMD_BOUNDS);
        set_panel(33, 5);
        do_stamp(32, 4, 0, 16'hFFFF, MODE_OR);
        do_probe(32, 4);
        do_probe(33, 4);
        do_scan(CMD_BOUNDS);
        set_panel(8, 1);
        do_stamp(0, 0, 0, 16'hFFFF, MODE_REPLACE);
        do_probe(7, 0);
        do_probe(8, 0);
        do_scan(CMD_BOUNDS);
        set_panel(256, 64);
        do_scan(CMD_BOUNDS);
    endtask

    task automatic test_output_stall();
        settle_results();
        steady_flow = 1'b1;
        hold_request = STALL_HOLD;
        for (int i = 0; i < 10; i++) do_probe($urandom_range(0, 40), $urandom_range(0, 40));
        steady_flow = 1'b0;
    endtask

    task automatic random_mix(input int quota);
        int    sent;
        int    r;
        int    x;
        int    y;
        int    lines;
        mode_t mode;
        sent = 0;
        while (sent < quota) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                // a glyph of one up to GLYPH_ROWS lines, one line per transfer
                x = pick_stamp_x();
                y = pick_row();
                lines = $urandom_range(1, GLYPH_ROWS);
                mode = mode_t'($urandom_range(0, 3));
                for (int i = 0; i < lines; i++) do_stamp(x, y, i, $urandom(), mode);
                sent += lines;
            end else begin
                if (r < 60) begin
                    do_stamp(($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                             : pick_stamp_x(), pick_row(), $urandom_range(0, 15),
                             $urandom(), mode_t'($urandom_range(0, 3)));
                end else if (r < 90) begin
                    do_probe(($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
                             : $urandom_range(0, eff_width() + 8),
                             ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                             : $urandom_range(0, eff_height() + 2));
                end else if (r < 93) begin
                    do_scan(CMD_CLEAR);
                end else begin
                    do_scan(CMD_BOUNDS);
                end
                sent++;
            end
        end
    endtask

    task automatic test_random_traffic();
        int w;
        int h;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin w = 256; h = 64; end
                1: begin w = 511; h = 127; end
                default: begin
                    case ($urandom_range(0, 6))
                        0: w = 8;
                        1: w = 31;
                        2: w = 33;
                        3: w = 100;
                        4: w = 200;
                        5: w = 300;
                        default: w = $urandom_range(0, 511);
                    endcase
                    case ($urandom_range(0, 5))
                        0: h = 1;
                        1: h = 7;
                        2: h = 33;
                        3: h = 63;
                        4: h = 100;
                        default: h = $urandom_range(0, 127);
                    endcase
                end
            endcase
            set_panel(w, h);
            steady_flow = (phase == 0);
            random_mix(110);
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        foreach (panel_bits[i]) panel_bits[i] = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_commands();
        test_register_extremes();
        test_output_stall();
        test_random_traffic();
        settle_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_answers.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_answers.size());
            mismatches++;
        end
        $display("Sent %0d commands over %0d panel settings, checked %0d results",
                 n_commands, n_settings, n_answers);
        $display("Saw %0d lit dot probes and %0d wide bounding boxes, %0d mismatches",
                 n_lit, n_boxes, mismatches);
        if (mismatches == 0) begin
            $display("dot_matrix_glyph_blitter_top test passed");
        end else begin
            $display("dot_matrix_glyph_blitter_top test failed");
        end
        $finish;
    end

endmodule
